/* sv/tabulated_inverse_cdf_sampler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the inverse CDF sampler
// Shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TABULATED_INVERSE_CDF_SAMPLER_MACROS_SVH
`define TABULATED_INVERSE_CDF_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TICS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TICS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tics_pkg.sv */
// ----------------------------------------------------------------------------
// Inverse CDF sampler package
// Field widths, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tics_pkg;

    localparam int FREQ_W   = 53;
    localparam int BW_W     = 48;
    localparam int IDX_W    = 10;
    localparam int PROB_W   = 32;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;
    localparam int CFG_W    = 53;

    localparam logic [FREQ_W-1:0] FREQ_MAX       = {FREQ_W{1'b1}};
    localparam logic [FREQ_W-1:0] MIN_FREQ_RESET = 53'd3288465385000000;
    localparam logic [BW_W-1:0]   BIN_W_RESET    = 48'd1928718701857;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_MIN_FREQ  = 1'b0;
    localparam logic CFG_BIN_WIDTH = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* sv/tics_table.sv */
// ----------------------------------------------------------------------------
// CDF table memory
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tics_table
    import tics_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [PROB_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [PROB_W-1:0] rdata
);

    logic [PROB_W-1:0] mem [DEPTH];
    logic [PROB_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tics_div.sv */
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(n * 2^32 / w) for n < w, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tics_div
    import tics_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROB_W-1:0] dividend,
    input  logic [PROB_W-1:0] divisor,
    output logic [PROB_W-1:0] quotient,
    output div_stat_t         stat
);

    localparam int CNT_W = $clog2(PROB_W);

    logic [PROB_W-1:0] rem_reg, rem_next;
    logic [PROB_W-1:0] quo_reg, quo_next;
    logic [PROB_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROB_W:0]   shifted;
    logic [PROB_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
            cnt_next  = CNT_W'(PROB_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[PROB_W-1:0];
                quo_next = {quo_reg[PROB_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[PROB_W-1:0];
                quo_next = {quo_reg[PROB_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* sv/tabulated_inverse_cdf_sampler.sv */
// Sequence: a sample word bisects the table, reads the two bounding CDF entries, then divides,
// multiplies and sums before its result word; an empty bin, or one whose uniform value is at or
// above its upper entry, skips the divider wait and the product stage.
// Throughput: one sample at a time, the next word is taken in the cycle after the result word is
// loaded; a load word is taken every idle cycle. Reset clears control state and restores both
// configuration registers; the table contents are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
// Tabulated inverse CDF sampler
// Bisects a loaded CDF table for a uniform value and interpolates a frequency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tabulated_inverse_cdf_sampler_macros.svh"

module tabulated_inverse_cdf_sampler
    import tics_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [9:0] entry_index, [41:10] entry_value, [73:42] uniform_value, [79:74] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [52:0] frequency, [62:53] bin_index, [63] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [0] empty_bin
    output logic                m_tuser,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int EDGE_W = AW + BW_W;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_SRCH = 13'b0000000000010,
        ST_CMP  = 13'b0000000000100,
        ST_RD0  = 13'b0000000001000,
        ST_RD1  = 13'b0000000010000,
        ST_RDW  = 13'b0000000100000,
        ST_PREP = 13'b0000001000000,
        ST_DIV  = 13'b0000010000000,
        ST_MUL  = 13'b0000100000000,
        ST_SUM1 = 13'b0001000000000,
        ST_SUM2 = 13'b0010000000000,
        ST_SUM3 = 13'b0100000000000,
        ST_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [FREQ_W-1:0] min_freq_reg;
    logic [BW_W-1:0]   bin_w_reg;

    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic [PROB_W-1:0] u_reg, u_next;
    logic [PROB_W-1:0] c0_reg, c0_next;
    logic [PROB_W-1:0] c1_reg, c1_next;
    logic              empty_reg, empty_next;
    logic              full_reg, full_next;

    logic [AW+15:0]    edge_hi_reg;
    logic [AW+31:0]    edge_lo_reg;
    logic [47:0]       p_hi_reg;
    logic [63:0]       p_lo_reg;
    logic [EDGE_W-1:0] edge_reg;
    logic [BW_W:0]     delta_reg;
    logic [FREQ_W-1:0] freq1_reg;
    logic [FREQ_W-1:0] res_freq_reg;

    logic              out_valid_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_empty_reg;
    logic              out_load;

    logic              in_accept;
    logic              tbl_we;
    logic              tbl_re;
    logic [AW-1:0]     tbl_raddr;
    logic [PROB_W-1:0] tbl_rdata;
    logic [AW:0]       mid_sum;
    logic [AW-1:0]     span;
    logic [PROB_W-1:0] w_c;
    logic [PROB_W-1:0] n_c;
    logic              div_start;
    logic [PROB_W-1:0] frac;
    div_stat_t         div_stat;
    logic [64:0]       base_sum;
    logic [FREQ_W:0]   final_sum;
    logic [BW_W-1:0]   addend;

    logic [IDX_W-1:0]  in_index;
    logic [PROB_W-1:0] in_entry;
    logic [PROB_W-1:0] in_uniform;

    assign in_index   = s_tdata[IDX_W-1:0];
    assign in_entry   = s_tdata[IDX_W+PROB_W-1:IDX_W];
    assign in_uniform = s_tdata[IDX_W+2*PROB_W-1:IDX_W+PROB_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign tbl_we    = in_accept && (s_tuser == OP_LOAD)
                       && (32'(in_index) < 32'(TABLE_DEPTH));

    tics_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(in_index)),
        .wdata (in_entry),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    tics_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_c),
        .divisor  (w_c),
        .quotient (frac),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg <= MIN_FREQ_RESET;
            bin_w_reg    <= BIN_W_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_FREQ:  min_freq_reg <= cfg_data[FREQ_W-1:0];
                CFG_BIN_WIDTH: bin_w_reg    <= cfg_data[BW_W-1:0];
                default:       min_freq_reg <= min_freq_reg;
            endcase
        end
    end

    always_comb
    begin
        mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
        span       = hi_reg - lo_reg;
        w_c        = c1_reg - c0_reg;
        if (u_reg < c0_reg)
        begin
            n_c = '0;
        end
        else if (u_reg > c1_reg)
        begin
            n_c = w_c;
        end
        else
        begin
            n_c = u_reg - c0_reg;
        end
        base_sum   = 65'(edge_reg) + 65'(min_freq_reg);
        addend     = full_reg ? bin_w_reg : delta_reg[BW_W-1:0];
        final_sum  = {1'b0, freq1_reg} + (FREQ_W+1)'(addend);
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        u_next     = u_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        empty_next = empty_reg;
        full_next  = full_reg;
        tbl_re     = 1'b0;
        tbl_raddr  = lo_reg;
        div_start  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == OP_SAMPLE))
                begin
                    lo_next    = '0;
                    hi_next    = AW'(TABLE_DEPTH - 1);
                    u_next     = in_uniform;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (span > AW'(1))
                begin
                    tbl_re     = 1'b1;
                    tbl_raddr  = mid_sum[AW:1];
                    mid_next   = mid_sum[AW:1];
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_RD0;
                end
            end
            ST_CMP:
            begin
                if (u_reg < tbl_rdata)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg;
                end
                state_next = ST_SRCH;
            end
            ST_RD0:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = lo_reg;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = lo_reg + AW'(1);
                c0_next    = tbl_rdata;
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                c1_next    = tbl_rdata;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                empty_next = (c1_reg <= c0_reg);
                full_next  = (n_c >= w_c);
                if ((c1_reg <= c0_reg) || (n_c >= w_c))
                begin
                    state_next = ST_SUM1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM1;
            ST_SUM1: state_next = ST_SUM2;
            ST_SUM2: state_next = ST_SUM3;
            ST_SUM3: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        u_reg     <= u_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
        if (state_reg == ST_PREP)
        begin
            edge_hi_reg <= (AW+16)'(lo_reg) * (AW+16)'(bin_w_reg[BW_W-1:32]);
            edge_lo_reg <= (AW+32)'(lo_reg) * (AW+32)'(bin_w_reg[31:0]);
        end
        if (state_reg == ST_MUL)
        begin
            p_hi_reg <= 48'(bin_w_reg[BW_W-1:32]) * 48'(frac);
            p_lo_reg <= 64'(bin_w_reg[31:0]) * 64'(frac);
        end
        if (state_reg == ST_SUM1)
        begin
            edge_reg  <= {edge_hi_reg, 32'b0} + EDGE_W'(edge_lo_reg);
            delta_reg <= (BW_W+1)'(p_hi_reg) + (BW_W+1)'(p_lo_reg[63:32]);
        end
        if (state_reg == ST_SUM2)
        begin
            freq1_reg <= (base_sum > 65'(FREQ_MAX)) ? FREQ_MAX : base_sum[FREQ_W-1:0];
        end
        if (state_reg == ST_SUM3)
        begin
            if (empty_reg)
            begin
                res_freq_reg <= freq1_reg;
            end
            else
            begin
                res_freq_reg <= final_sum[FREQ_W] ? FREQ_MAX : final_sum[FREQ_W-1:0];
            end
        end
        if (out_load)
        begin
            out_freq_reg  <= res_freq_reg;
            out_idx_reg   <= IDX_W'(lo_reg);
            out_empty_reg <= empty_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_idx_reg, out_freq_reg};
    assign m_tuser  = out_empty_reg;

    `TICS_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, s_tready, !div_stat.busy,
        "divider busy while accepting words")
    `TICS_ASSERT_IMP(a_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV,
        "divider finished outside its wait state")
    `TICS_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || m_tready,
        "result register overwritten before it was taken")
    `TICS_ASSERT_IMP(a_search_order, clk, rst_n, state_reg == ST_SRCH, lo_reg < hi_reg,
        "search bounds crossed")
    `TICS_ASSERT_NXT(a_load_holds, clk, rst_n, out_load, m_tvalid,
        "loaded result not presented")

endmodule
